@@ hdl/waveform_statistics_meter_macros.svh @@
// ----------------------------------------------------------------------------
// Waveform statistics meter assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_STATISTICS_METER_MACROS_SVH
`define WAVEFORM_STATISTICS_METER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define WSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ hdl/wsm_pkg.sv @@
// ----------------------------------------------------------------------------
// wsm_pkg
// Widths, mode codes and controller/datapath interface types of the
// waveform statistics meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsm_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 17;
  localparam int MODE_W   = 3;

  // run limit and accumulator widths
  localparam int MAX_SAMPLES = 65536;
  localparam int COUNT_W     = 17;
  localparam int SUM_W       = 32;
  localparam int SQ_W        = 47;
  localparam int PROD_W      = 64;
  localparam int DEN_W       = 33;
  localparam int ROOT_W      = 32;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SAMPLES);
  localparam logic [ROOT_W-1:0]  SQRT_TOP  = ROOT_W'(1) << (ROOT_W - 2);

  // iteration counts of the multi-cycle units
  localparam int MUL_STEPS  = COUNT_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int SQRT_STEPS = ROOT_W / 2;
  localparam int STEP_W     = 7;

  // mode register codes
  localparam logic [MODE_W-1:0] MODE_DC     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AC_RMS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MAX    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AVG    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_P2P    = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic acc;         // accumulate the accepted sample
    logic mul_start;   // load multiplier, square and n*n
    logic mul_step;    // one shift-add step of n*sumsq
    logic div_var;     // load divider with variance terms
    logic div_dc;      // load divider with |sum| / n
    logic div_step;    // one restoring division step
    logic sqrt_start;  // load root unit from the quotient
    logic sqrt_step;   // one digit of the square root
    logic load_out;    // capture result word, clear run
  } wsm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
  } wsm_status_t;

endpackage

`default_nettype wire

@@ hdl/wsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// wsm_ctrl
// Sequencer: accepts samples, then at the end of a run steps the multiplier,
// divider and root unit of the datapath as the mode needs and hands off the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 last_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire wsm_pkg::wsm_status_t status_i,
  output wsm_pkg::wsm_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_PREP,
    ST_MUL,
    ST_VAR,
    ST_DIV,
    ST_SQLD,
    ST_SQRT,
    ST_LOAD
  } state_e;

  state_e                     state_q, state_d;
  logic [wsm_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       in_acc;
  logic                       out_free;
  logic                       is_ac;
  logic                       is_dc;

  assign in_ready_o  = (state_q == ST_ACC);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign is_ac       = (status_i.mode == wsm_pkg::MODE_AC_RMS);
  assign is_dc       = status_i.mode inside {wsm_pkg::MODE_DC, wsm_pkg::MODE_AVG};

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_ACC: begin
        cmd_o.acc = in_acc;
        if (in_acc && last_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cnt_d = '0;
        if (is_ac) begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_MUL;
        end else if (is_dc) begin
          cmd_o.div_dc = 1'b1;
          state_d      = ST_DIV;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == wsm_pkg::STEP_W'(wsm_pkg::MUL_STEPS - 1)) begin
          state_d = ST_VAR;
        end
      end
      ST_VAR: begin
        cmd_o.div_var = 1'b1;
        cnt_d         = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == wsm_pkg::STEP_W'(wsm_pkg::DIV_STEPS - 1)) begin
          state_d = is_ac ? ST_SQLD : ST_LOAD;
        end
      end
      ST_SQLD: begin
        cmd_o.sqrt_start = 1'b1;
        cnt_d            = '0;
        state_d          = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == wsm_pkg::STEP_W'(wsm_pkg::SQRT_STEPS - 1)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // wait for the output register to drain
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/wsm_datapath.sv @@
// ----------------------------------------------------------------------------
// wsm_datapath
// Run accumulators, shift-add multiplier, restoring divider, digit-by-digit
// square root, result select and output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsm_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire wsm_pkg::wsm_cmd_t                   cmd_i,
  output wsm_pkg::wsm_status_t                     status_o,
  input  wire logic                                cfg_valid_i,
  input  wire logic [wsm_pkg::MODE_W-1:0]          cfg_mode_i,
  input  wire logic signed [wsm_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [wsm_pkg::VALUE_W-1:0]       value_o,
  output logic signed [wsm_pkg::SAMPLE_W-1:0]      min_value_o,
  output logic signed [wsm_pkg::SAMPLE_W-1:0]      max_value_o,
  output logic                                     overflow_o
);

  localparam int SW = wsm_pkg::SAMPLE_W;
  localparam int VW = wsm_pkg::VALUE_W;
  localparam int CW = wsm_pkg::COUNT_W;
  localparam int UW = wsm_pkg::SUM_W;
  localparam int QW = wsm_pkg::SQ_W;
  localparam int PW = wsm_pkg::PROD_W;
  localparam int DW = wsm_pkg::DEN_W;
  localparam int RW = wsm_pkg::ROOT_W;

  // mode register
  logic [wsm_pkg::MODE_W-1:0] mode_q;

  // run state
  logic signed [SW-1:0] min_q, max_q;
  logic signed [UW-1:0] sum_q;
  logic [QW-1:0]        sumsq_q;
  logic [CW-1:0]        count_q;
  logic                 ovf_q;

  // arithmetic unit registers
  logic [PW-1:0] prod_q, mcand_q, sq_q, quo_q;
  logic [CW-1:0] mplier_q;
  logic [DW-1:0] den_q, dvs_q, rem_q;
  logic [RW-1:0] x_q, root_q, bit_q;

  // output word
  logic signed [VW-1:0] value_q;
  logic signed [SW-1:0] omin_q, omax_q;
  logic                 oovf_q;

  logic                 first;
  logic                 full;
  logic signed [2*SW-1:0] ssq;
  logic [UW-1:0]        mag;
  logic [PW-1:0]        mag_sq;
  logic [2*CW-1:0]      n_sq;
  logic [DW+1:0]        trial;
  logic [RW-1:0]        rt_sum;
  logic [VW-1:0]        q_up;
  logic signed [VW-1:0] mean;
  logic signed [VW-1:0] sel;

  assign status_o.mode = mode_q;

  assign first  = (count_q == '0);
  assign full   = (count_q >= wsm_pkg::MAX_COUNT);
  assign ssq    = sample_i * sample_i;
  assign mag    = sum_q[UW-1] ? (~$unsigned(sum_q) + UW'(1)) : $unsigned(sum_q);
  assign mag_sq = PW'(mag) * PW'(mag);
  assign n_sq   = (2*CW)'(count_q) * (2*CW)'(count_q);
  assign trial  = {1'b0, rem_q, quo_q[PW-1]} - {2'b00, dvs_q};
  assign rt_sum = root_q + bit_q;

  // floor of sum / n from |sum| / n
  assign q_up = quo_q[VW-1:0] + VW'(|rem_q);
  assign mean = sum_q[UW-1] ? $signed(VW'(0) - q_up) : $signed(quo_q[VW-1:0]);

  // result select
  always_comb begin
    case (mode_q)
      wsm_pkg::MODE_DC,
      wsm_pkg::MODE_AVG:    sel = mean;
      wsm_pkg::MODE_AC_RMS: sel = $signed(root_q[VW-1:0]);
      wsm_pkg::MODE_MIN:    sel = VW'(min_q);
      wsm_pkg::MODE_MAX:    sel = VW'(max_q);
      wsm_pkg::MODE_P2P:    sel = VW'(max_q) - VW'(min_q);
      default:              sel = '0;
    endcase
    if (first) begin
      sel = '0;
    end
  end

  // mode register and run accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= wsm_pkg::MODE_DC;
      min_q   <= '0;
      max_q   <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_mode_i;
      end
      if (cmd_i.load_out) begin
        min_q   <= '0;
        max_q   <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.acc) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          if (first || (sample_i < min_q)) begin
            min_q <= sample_i;
          end
          if (first || (sample_i > max_q)) begin
            max_q <= sample_i;
          end
          sum_q   <= sum_q + UW'(sample_i);
          sumsq_q <= sumsq_q + QW'($unsigned(ssq));
          count_q <= count_q + CW'(1);
        end
      end
    end
  end

  // multiplier, divider and root unit
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      prod_q   <= '0;
      mcand_q  <= PW'(sumsq_q);
      mplier_q <= count_q;
      sq_q     <= mag_sq;
      den_q    <= n_sq[DW-1:0];
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end

    if (cmd_i.div_var) begin
      rem_q <= '0;
      quo_q <= prod_q - sq_q;
      dvs_q <= den_q;
    end else if (cmd_i.div_dc) begin
      rem_q <= '0;
      quo_q <= PW'(mag);
      dvs_q <= DW'(count_q);
    end else if (cmd_i.div_step) begin
      if (!trial[DW+1]) begin
        rem_q <= trial[DW-1:0];
        quo_q <= {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DW-2:0], quo_q[PW-1]};
        quo_q <= {quo_q[PW-2:0], 1'b0};
      end
    end

    if (cmd_i.sqrt_start) begin
      x_q    <= quo_q[RW-1:0];
      root_q <= '0;
      bit_q  <= wsm_pkg::SQRT_TOP;
    end else if (cmd_i.sqrt_step) begin
      if (x_q >= rt_sum) begin
        x_q    <= x_q - rt_sum;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end

    // output word
    if (cmd_i.load_out) begin
      value_q <= sel;
      omin_q  <= min_q;
      omax_q  <= max_q;
      oovf_q  <= ovf_q;
    end
  end

  assign value_o     = value_q;
  assign min_value_o = omin_q;
  assign max_value_o = omax_q;
  assign overflow_o  = oovf_q;

endmodule

`default_nettype wire

@@ hdl/waveform_statistics_meter.sv @@
// ----------------------------------------------------------------------------
// waveform_statistics_meter
// Min, max, mean, AC RMS and peak-to-peak of a run of signed samples.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while a run accumulates.
// End of run: the result word is loaded once the output register is free; min, max
//   and peak-to-peak need no arithmetic, dc/average first run the 64-step divider,
//   and AC RMS runs the 17-step multiplier, 64-step divider and 16-step root.
// in_ready_o is low from the last sample until the result is in the output.
// Reset clears the run accumulators, the output valid and sets mode to dc.
`timescale 1ns / 1ps
`default_nettype none

module waveform_statistics_meter (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [wsm_pkg::MODE_W-1:0]          cfg_mode_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [wsm_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                last_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [wsm_pkg::VALUE_W-1:0]       value_o,
  output logic signed [wsm_pkg::SAMPLE_W-1:0]      min_value_o,
  output logic signed [wsm_pkg::SAMPLE_W-1:0]      max_value_o,
  output logic                                     overflow_o
);

  wsm_pkg::wsm_cmd_t    cmd;
  wsm_pkg::wsm_status_t status;

  // the user must write mode only between runs; the block does not enforce it
  assign cfg_ready_o = 1'b1;

  wsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wsm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_mode_i  (cfg_mode_i),
    .sample_i    (sample_i),
    .value_o     (value_o),
    .min_value_o (min_value_o),
    .max_value_o (max_value_o),
    .overflow_o  (overflow_o)
  );

endmodule

`default_nettype wire

@@ hdl/wsm_checker.sv @@
// ----------------------------------------------------------------------------
// wsm_checker
// Port-level checks of the waveform statistics meter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "waveform_statistics_meter_macros.svh"

module wsm_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic                                last_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [wsm_pkg::VALUE_W-1:0]  value_o,
  input wire logic signed [wsm_pkg::SAMPLE_W-1:0] min_value_o,
  input wire logic signed [wsm_pkg::SAMPLE_W-1:0] max_value_o
);

  // a pending result word holds until taken
  `WSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `WSM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
    $stable(value_o) && $stable(min_value_o) && $stable(max_value_o))

  // end of run stops intake while the result is worked out
  `WSM_ASSERT_NEXT(a_run_end, clk_i, rst_ni, in_valid_i && in_ready_o && last_i, !in_ready_o)

  // a reported run never has min above max
  `WSM_ASSERT_SAME(a_min_max, clk_i, rst_ni, out_valid_o, min_value_o <= max_value_o)

endmodule

bind waveform_statistics_meter wsm_checker u_wsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_o     (value_o),
  .min_value_o (min_value_o),
  .max_value_o (max_value_o)
);

`default_nettype wire
